### src/mfat_pkg.sv
// ----------------------------------------------------------------------------
// mfat_pkg
// Shared types and constants of the motor feedback angle tracker: register
// map, angle constants and the configuration bundle.
// ----------------------------------------------------------------------------
package mfat_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int ID_W       = 11;
    localparam int ANGLE_W    = 13;
    localparam int SPEED_W    = 16;
    localparam int SUM_W      = 32;
    localparam int MASK_W     = 9;
    localparam int SLOT_W     = 2;
    localparam int DELTA_W    = ANGLE_W + 2;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [ID_W-1:0]    BASE_ID      = 11'h201;
    localparam logic [ID_W-1:0]    LAST_ID      = 11'h209;
    localparam logic [DELTA_W-1:0] TURN_COUNTS  = 15'd8192;
    localparam logic [DELTA_W-1:0] HALF_TURN    = 15'd4096;
    localparam logic [SPEED_W-1:0] SPEED_LOW_RST = 16'd9000;

    localparam logic [ADDR_W-1:0] ADDR_SLOT_ID_0   = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_ID_1   = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_ID_2   = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_SLOT_ID_3   = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_ACC_MASK    = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_MON_SLOT    = 5'd20;

    typedef struct packed {
        logic [SLOT_COUNT-1:0][ID_W-1:0] slot_id;
        logic [MASK_W-1:0]               accumulate_mask;
        logic [SLOT_W-1:0]               monitored_slot;
    } cfg_t;

endpackage

### src/mfat_if.sv
// ----------------------------------------------------------------------------
// mfat_in_if / mfat_out_if
// Valid/ready channels carrying feedback frames in and tracker results out.
// ----------------------------------------------------------------------------
interface mfat_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mfat_pkg::ID_W-1:0]            frame_id;
    logic [mfat_pkg::ANGLE_W-1:0]         rotor_angle;
    logic signed [mfat_pkg::SPEED_W-1:0]  speed_rpm;

    modport source (output valid, frame_id, rotor_angle, speed_rpm, input ready);
    modport sink   (input valid, frame_id, rotor_angle, speed_rpm, output ready);
endinterface

interface mfat_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 matched;
    logic [mfat_pkg::SLOT_W-1:0]          slot;
    logic                                 first_frame;
    logic signed [mfat_pkg::SUM_W-1:0]    angle_sum;
    logic signed [mfat_pkg::SPEED_W-1:0]  speed_low;
    logic signed [mfat_pkg::SPEED_W-1:0]  speed_high;

    modport source (output valid, matched, slot, first_frame, angle_sum,
                    speed_low, speed_high, input ready);
    modport sink   (input valid, matched, slot, first_frame, angle_sum,
                    speed_low, speed_high, output ready);
endinterface

### src/mfat_cfg.sv
// ----------------------------------------------------------------------------
// mfat_cfg
// APB register bank: slot identifiers, accumulate mask and monitored slot.
// ----------------------------------------------------------------------------
module mfat_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfat_pkg::ADDR_W-1:0]   paddr,
    input  logic [mfat_pkg::DATA_W-1:0]   pwdata,
    output logic [mfat_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mfat_pkg::cfg_t                cfg
);

    mfat_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_id[0]      <= 11'd513;
            cfg_reg.slot_id[1]      <= 11'd514;
            cfg_reg.slot_id[2]      <= 11'd515;
            cfg_reg.slot_id[3]      <= 11'd516;
            cfg_reg.accumulate_mask <= '0;
            cfg_reg.monitored_slot  <= 2'd3;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                mfat_pkg::ADDR_SLOT_ID_0: cfg_reg.slot_id[0] <= pwdata[mfat_pkg::ID_W-1:0];
                mfat_pkg::ADDR_SLOT_ID_1: cfg_reg.slot_id[1] <= pwdata[mfat_pkg::ID_W-1:0];
                mfat_pkg::ADDR_SLOT_ID_2: cfg_reg.slot_id[2] <= pwdata[mfat_pkg::ID_W-1:0];
                mfat_pkg::ADDR_SLOT_ID_3: cfg_reg.slot_id[3] <= pwdata[mfat_pkg::ID_W-1:0];
                mfat_pkg::ADDR_ACC_MASK:
                    cfg_reg.accumulate_mask <= pwdata[mfat_pkg::MASK_W-1:0];
                mfat_pkg::ADDR_MON_SLOT:
                    cfg_reg.monitored_slot <= pwdata[mfat_pkg::SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            mfat_pkg::ADDR_SLOT_ID_0: prdata = 32'(cfg_reg.slot_id[0]);
            mfat_pkg::ADDR_SLOT_ID_1: prdata = 32'(cfg_reg.slot_id[1]);
            mfat_pkg::ADDR_SLOT_ID_2: prdata = 32'(cfg_reg.slot_id[2]);
            mfat_pkg::ADDR_SLOT_ID_3: prdata = 32'(cfg_reg.slot_id[3]);
            mfat_pkg::ADDR_ACC_MASK:  prdata = 32'(cfg_reg.accumulate_mask);
            mfat_pkg::ADDR_MON_SLOT:  prdata = 32'(cfg_reg.monitored_slot);
            default:                  prdata = '0;
        endcase
    end

endmodule

### src/mfat_core.sv
// ----------------------------------------------------------------------------
// mfat_core
// Input register, slot match, angle unwrap and speed trackers, result register.
// ----------------------------------------------------------------------------
module mfat_core
#(
    parameter int MOTORS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mfat_pkg::cfg_t    cfg,
    mfat_in_if.sink           in_chan,
    mfat_out_if.source        out_chan
);

    // input register
    logic                                s1_valid_reg;
    logic [mfat_pkg::ID_W-1:0]           s1_id_reg;
    logic [mfat_pkg::ANGLE_W-1:0]        s1_angle_reg;
    logic signed [mfat_pkg::SPEED_W-1:0] s1_speed_reg;

    // per-slot state
    logic [mfat_pkg::ANGLE_W-1:0]        prev_angle_reg [mfat_pkg::SLOT_COUNT];
    logic [mfat_pkg::SUM_W-1:0]          total_reg      [mfat_pkg::SLOT_COUNT];
    logic [mfat_pkg::SLOT_COUNT-1:0]     seen_reg;
    logic signed [mfat_pkg::SPEED_W-1:0] slot_speed_reg [mfat_pkg::SLOT_COUNT];
    logic signed [mfat_pkg::SPEED_W-1:0] lowest_reg;
    logic signed [mfat_pkg::SPEED_W-1:0] highest_reg;

    // result register
    logic                                out_valid_reg;
    logic                                out_matched_reg;
    logic [mfat_pkg::SLOT_W-1:0]         out_slot_reg;
    logic                                out_first_reg;
    logic [mfat_pkg::SUM_W-1:0]          out_sum_reg;

    logic                                advance;
    logic                                hit;
    logic [mfat_pkg::SLOT_W-1:0]         hit_slot;
    logic                                acc_en;
    logic [mfat_pkg::ID_W-1:0]           id_rel;
    logic signed [mfat_pkg::DELTA_W-1:0] delta_raw;
    logic signed [mfat_pkg::DELTA_W-1:0] delta;
    logic [mfat_pkg::SUM_W-1:0]          delta_ext;
    logic [mfat_pkg::SUM_W-1:0]          total_next;
    logic [mfat_pkg::ANGLE_W-1:0]        prev_angle_next;
    logic                                first_next;
    logic signed [mfat_pkg::SPEED_W-1:0] mon_speed;
    logic signed [mfat_pkg::SPEED_W-1:0] lowest_next;
    logic signed [mfat_pkg::SPEED_W-1:0] highest_next;

    assign advance       = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_chan.ready)
            s1_valid_reg <= in_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            s1_id_reg    <= in_chan.frame_id;
            s1_angle_reg <= in_chan.rotor_angle;
            s1_speed_reg <= in_chan.speed_rpm;
        end
    end

    // lowest-numbered matching slot wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = MOTORS - 1; i >= 0; i--)
        begin
            if (cfg.slot_id[i] == s1_id_reg)
            begin
                hit      = 1'b1;
                hit_slot = mfat_pkg::SLOT_W'(i);
            end
        end
    end

    assign id_rel = s1_id_reg - mfat_pkg::BASE_ID;
    assign acc_en = (s1_id_reg >= mfat_pkg::BASE_ID) && (s1_id_reg <= mfat_pkg::LAST_ID)
                    && cfg.accumulate_mask[id_rel[3:0]];

    assign delta_raw = $signed({2'b00, s1_angle_reg})
                     - $signed({2'b00, prev_angle_reg[hit_slot]});

    always_comb
    begin
        priority if (delta_raw > $signed(mfat_pkg::HALF_TURN))
            delta = delta_raw - $signed(mfat_pkg::TURN_COUNTS);
        else if (delta_raw < -$signed(mfat_pkg::HALF_TURN))
            delta = delta_raw + $signed(mfat_pkg::TURN_COUNTS);
        else
            delta = delta_raw;
    end

    assign delta_ext = {{(mfat_pkg::SUM_W - mfat_pkg::DELTA_W){delta[mfat_pkg::DELTA_W-1]}},
                        delta};

    always_comb
    begin
        first_next      = 1'b0;
        total_next      = total_reg[hit_slot];
        prev_angle_next = prev_angle_reg[hit_slot];
        if (!seen_reg[hit_slot])
        begin
            first_next      = 1'b1;
            prev_angle_next = s1_angle_reg;
        end
        else if (acc_en)
        begin
            total_next      = total_reg[hit_slot] + delta_ext;
            prev_angle_next = s1_angle_reg;
        end
    end

    assign mon_speed    = (hit && hit_slot == cfg.monitored_slot)
                        ? s1_speed_reg : slot_speed_reg[cfg.monitored_slot];
    assign lowest_next  = (mon_speed < lowest_reg)  ? mon_speed : lowest_reg;
    assign highest_next = (mon_speed > highest_reg) ? mon_speed : highest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mfat_pkg::SLOT_COUNT; i++)
            begin
                prev_angle_reg[i] <= '0;
                total_reg[i]      <= '0;
                slot_speed_reg[i] <= '0;
            end
            seen_reg    <= '0;
            lowest_reg  <= mfat_pkg::SPEED_LOW_RST;
            highest_reg <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            if (hit)
            begin
                prev_angle_reg[hit_slot] <= prev_angle_next;
                total_reg[hit_slot]      <= total_next;
                slot_speed_reg[hit_slot] <= s1_speed_reg;
                seen_reg[hit_slot]       <= 1'b1;
            end
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_matched_reg <= hit;
            out_slot_reg    <= hit ? hit_slot : '0;
            out_first_reg   <= hit && first_next;
            out_sum_reg     <= hit ? total_next : '0;
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.matched     = out_matched_reg;
    assign out_chan.slot        = out_slot_reg;
    assign out_chan.first_frame = out_first_reg;
    assign out_chan.angle_sum   = out_sum_reg;
    assign out_chan.speed_low   = lowest_reg;
    assign out_chan.speed_high  = highest_reg;

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_matched_reg) |-> (out_slot_reg == '0 && out_sum_reg == '0
                                                 && !out_first_reg))
        else $error("unmatched result carries slot data");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (lowest_reg <= highest_reg))
        else $error("speed minimum above maximum");

    a_first_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && hit && first_next) |=> seen_reg[$past(hit_slot)])
        else $error("first frame did not mark slot as seen");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_chan.ready) |=> $stable(out_sum_reg) && out_valid_reg)
        else $error("result lost under stall");

endmodule

### src/motor_feedback_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_unit
// Matches feedback frames to motor slots, unwraps rotor angle into a
// multi-turn sum and tracks speed extremes of one monitored slot.
// ----------------------------------------------------------------------------
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while the result channel is not stalled;
// the slot state loop (match, wrapped delta, 32-bit add) closes without a pipeline register.
// Reset: asynchronous, clears slot state, speed trackers to 9000 / 0,
// registers to their defaults.
module motor_feedback_angle_tracker_unit
#(
    parameter int MOTORS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    mfat_in_if.sink                       in_chan,
    mfat_out_if.source                    out_chan,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfat_pkg::ADDR_W-1:0]   paddr,
    input  logic [mfat_pkg::DATA_W-1:0]   pwdata,
    output logic [mfat_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    mfat_pkg::cfg_t cfg;

    mfat_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfat_core #(
        .MOTORS (MOTORS)
    ) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

endmodule

### dv/tb_motor_feedback_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_motor_feedback_angle_tracker_unit
// Sends feedback frames to the angle tracker with random gaps and random
// result back-pressure, and rewrites the slot map and the accumulation mask
// between phases. An in-bench model predicts each result: slot match, first
// frame latch, wrapped angle sum and speed extremes. Every result is checked
// against that prediction.
// ----------------------------------------------------------------------------
module tb_motor_feedback_angle_tracker_unit;
    import mfat_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int CHUNK_FRAMES  = 108;

    localparam logic [ADDR_W-1:0] SLOT_ADDR [SLOT_COUNT] =
        '{ADDR_SLOT_ID_0, ADDR_SLOT_ID_1, ADDR_SLOT_ID_2, ADDR_SLOT_ID_3};

    typedef struct packed {
        logic                      matched;
        logic [SLOT_W-1:0]         slot;
        logic                      first_frame;
        logic signed [SUM_W-1:0]   angle_sum;
        logic signed [SPEED_W-1:0] speed_low;
        logic signed [SPEED_W-1:0] speed_high;
    } tracker_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mfat_in_if  in_chan ();
    mfat_out_if out_chan ();

    motor_feedback_angle_tracker_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cfg_t                      model_cfg;
    logic [ANGLE_W-1:0]        last_angle [SLOT_COUNT];
    logic [SUM_W-1:0]          turn_sum [SLOT_COUNT];
    bit                        has_seen [SLOT_COUNT];
    logic signed [SPEED_W-1:0] held_speed [SLOT_COUNT];
    logic signed [SPEED_W-1:0] speed_floor;
    logic signed [SPEED_W-1:0] speed_ceiling;

    tracker_result_t    pending_reports [$];
    logic [ANGLE_W-1:0] drive_angle [SLOT_COUNT];

    int sender_idle;
    int receiver_idle;
    int frames_sent;
    int results_checked;
    int reg_writes;
    int mismatches;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_tracker_model();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            model_cfg.slot_id[i] = BASE_ID + ID_W'(i);
            last_angle[i]        = '0;
            turn_sum[i]          = '0;
            has_seen[i]          = 1'b0;
            held_speed[i]        = '0;
            drive_angle[i]       = '0;
        end
        model_cfg.accumulate_mask = '0;
        model_cfg.monitored_slot  = SLOT_W'(SLOT_COUNT - 1);
        speed_floor               = SPEED_LOW_RST;
        speed_ceiling             = '0;
    endfunction

    function automatic void apply_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        case (addr)
            ADDR_SLOT_ID_0: model_cfg.slot_id[0]      = data[ID_W-1:0];
            ADDR_SLOT_ID_1: model_cfg.slot_id[1]      = data[ID_W-1:0];
            ADDR_SLOT_ID_2: model_cfg.slot_id[2]      = data[ID_W-1:0];
            ADDR_SLOT_ID_3: model_cfg.slot_id[3]      = data[ID_W-1:0];
            ADDR_ACC_MASK:  model_cfg.accumulate_mask = data[MASK_W-1:0];
            ADDR_MON_SLOT:  model_cfg.monitored_slot  = data[SLOT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] expected_readback(logic [ADDR_W-1:0] addr);
        logic [DATA_W-1:0] value;
        value = '0;
        case (addr)
            ADDR_SLOT_ID_0: value = DATA_W'(model_cfg.slot_id[0]);
            ADDR_SLOT_ID_1: value = DATA_W'(model_cfg.slot_id[1]);
            ADDR_SLOT_ID_2: value = DATA_W'(model_cfg.slot_id[2]);
            ADDR_SLOT_ID_3: value = DATA_W'(model_cfg.slot_id[3]);
            ADDR_ACC_MASK:  value = DATA_W'(model_cfg.accumulate_mask);
            ADDR_MON_SLOT:  value = DATA_W'(model_cfg.monitored_slot);
            default: ;
        endcase
        return value;
    endfunction

    function automatic tracker_result_t track_frame(logic [ID_W-1:0] id,
                                                    logic [ANGLE_W-1:0] angle,
                                                    logic signed [SPEED_W-1:0] speed);
        tracker_result_t           r;
        int                        hit;
        int                        delta;
        logic [ID_W-1:0]           ident;
        logic signed [SPEED_W-1:0] watched;
        r   = '0;
        hit = -1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (model_cfg.slot_id[i] == id)
            begin
                hit = i;
            end
        end
        if (hit >= 0)
        begin
            r.matched       = 1'b1;
            r.slot          = SLOT_W'(hit);
            held_speed[hit] = speed;
            ident           = model_cfg.slot_id[hit];
            if (!has_seen[hit])
            begin
                last_angle[hit] = angle;
                has_seen[hit]   = 1'b1;
                r.first_frame   = 1'b1;
            end
            else if (ident >= BASE_ID && ident <= LAST_ID
                     && model_cfg.accumulate_mask[ident - BASE_ID])
            begin
                delta = int'(angle) - int'(last_angle[hit]);
                if (delta > int'(HALF_TURN))
                begin
                    delta -= int'(TURN_COUNTS);
                end
                else if (delta < -int'(HALF_TURN))
                begin
                    delta += int'(TURN_COUNTS);
                end
                turn_sum[hit]   = turn_sum[hit] + SUM_W'(delta);
                last_angle[hit] = angle;
            end
            r.angle_sum = turn_sum[hit];
        end
        watched = held_speed[model_cfg.monitored_slot];
        if (watched < speed_floor)
        begin
            speed_floor = watched;
        end
        if (watched > speed_ceiling)
        begin
            speed_ceiling = watched;
        end
        r.speed_low  = speed_floor;
        r.speed_high = speed_ceiling;
        return r;
    endfunction

    task automatic send_frame(input logic [ID_W-1:0] id, input logic [ANGLE_W-1:0] angle,
                              input logic signed [SPEED_W-1:0] speed);
        while ($urandom_range(99) < sender_idle)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid       <= 1'b1;
        in_chan.frame_id    <= id;
        in_chan.rotor_angle <= angle;
        in_chan.speed_rpm   <= speed;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
        pending_reports.push_back(track_frame(id, angle, speed));
        frames_sent++;
    endtask

    task automatic drain_results();
        in_chan.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        apply_register(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (prdata !== expected_readback(addr))
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("register 0x%0h: expected %0h actual %0h",
                         addr, expected_readback(addr), prdata);
            end
        end
        reg_writes++;
    endtask

    task automatic test_default_map();
        send_frame('0, '0, 16'sd0);
        send_frame('1, '1, -16'sd1);
        send_frame(BASE_ID, '0, 16'sd100);
        send_frame(BASE_ID, 13'd8191, 16'sd200);
        send_frame(BASE_ID + ID_W'(1), 13'd4096, -16'sd300);
        send_frame(BASE_ID + ID_W'(2), 13'd1, 16'sd400);
        send_frame(BASE_ID + ID_W'(3), 13'd8191, 16'sd500);
    endtask

    task automatic test_wrapped_delta();
        set_register(ADDR_ACC_MASK, DATA_W'({MASK_W{1'b1}}));
        set_register(ADDR_MON_SLOT, DATA_W'(0));
        send_frame(BASE_ID, 13'd4096, 16'sd600);
        send_frame(BASE_ID, 13'd0, -16'sd700);
        send_frame(BASE_ID, 13'd4097, 16'sd50);
        send_frame(BASE_ID, 13'd0, 16'sd60);
        send_frame(BASE_ID, 13'd8191, 16'sd70);
        send_frame(BASE_ID, 13'd0, 16'sd80);
        send_frame(BASE_ID, 13'd3000, 16'sd90);
        send_frame(BASE_ID, 13'd7200, 16'sd95);
        send_frame(BASE_ID + ID_W'(1), 13'd100, -16'sd900);
    endtask

    task automatic test_out_of_range_ids();
        set_register(ADDR_SLOT_ID_1, DATA_W'(BASE_ID - ID_W'(1)));
        set_register(ADDR_SLOT_ID_2, DATA_W'(LAST_ID + ID_W'(1)));
        set_register(ADDR_SLOT_ID_3, DATA_W'(LAST_ID));
        send_frame(BASE_ID - ID_W'(1), 13'd2000, 16'sd10);
        send_frame(BASE_ID - ID_W'(1), 13'd2500, 16'sd20);
        send_frame(LAST_ID + ID_W'(1), 13'd5000, 16'sd30);
        send_frame(LAST_ID + ID_W'(1), 13'd5100, 16'sd40);
        send_frame(LAST_ID, 13'd20, 16'sd1000);
        send_frame(LAST_ID, 13'd4000, -16'sd1000);
    endtask

    task automatic test_duplicate_ids();
        set_register(ADDR_SLOT_ID_2, DATA_W'(BASE_ID));
        set_register(ADDR_ACC_MASK, DATA_W'(1));
        set_register(ADDR_MON_SLOT, DATA_W'(2));
        send_frame(BASE_ID, 13'd1000, 16'sd32767);
        send_frame(BASE_ID, 13'd6000, -16'sd32768);
        set_register(ADDR_MON_SLOT, DATA_W'(0));
        send_frame(BASE_ID, 13'd6100, -16'sd32768);
        send_frame(BASE_ID, 13'd6200, 16'sd32767);
    endtask

    task automatic randomise_map(input int chunk);
        logic [ID_W-1:0] ident;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            case (chunk)
                0:       ident = BASE_ID + ID_W'(i);
                1:       ident = (i == 0) ? '0 : (i == 1) ? '1 : LAST_ID - ID_W'(i);
                default: ident = ($urandom_range(3) == 0) ? ID_W'($urandom)
                                                          : BASE_ID + ID_W'($urandom_range(8));
            endcase
            set_register(SLOT_ADDR[i], DATA_W'(ident));
        end
        case (chunk)
            0:       set_register(ADDR_ACC_MASK, DATA_W'({MASK_W{1'b1}}));
            1:       set_register(ADDR_ACC_MASK, DATA_W'(0));
            default: set_register(ADDR_ACC_MASK, DATA_W'($urandom_range(511)));
        endcase
        case (chunk)
            0:       set_register(ADDR_MON_SLOT, DATA_W'(0));
            1:       set_register(ADDR_MON_SLOT, DATA_W'(SLOT_COUNT - 1));
            default: set_register(ADDR_MON_SLOT, DATA_W'($urandom_range(SLOT_COUNT - 1)));
        endcase
    endtask

    task automatic test_random_tracking(input int send_pct, input int recv_pct);
        int                 pick;
        logic [ID_W-1:0]    id;
        logic [ANGLE_W-1:0] angle;
        sender_idle   = send_pct;
        receiver_idle = recv_pct;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            randomise_map(chunk);
            for (int n = 0; n < CHUNK_FRAMES; n++)
            begin
                pick = $urandom_range(SLOT_COUNT - 1);
                id   = ($urandom_range(9) == 0) ? ID_W'($urandom) : model_cfg.slot_id[pick];
                case ($urandom_range(9))
                    0:       angle = ANGLE_W'($urandom);
                    1:       angle = drive_angle[pick] + ANGLE_W'($urandom_range(4090, 4102));
                    2:       angle = drive_angle[pick] - ANGLE_W'($urandom_range(4090, 4102));
                    default: angle = drive_angle[pick] + ANGLE_W'($urandom_range(600))
                                     - ANGLE_W'(300);
                endcase
                drive_angle[pick] = angle;
                send_frame(id, angle, SPEED_W'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tracker_result_t observed;
        tracker_result_t wanted;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            observed.matched     = out_chan.matched;
            observed.slot        = out_chan.slot;
            observed.first_frame = out_chan.first_frame;
            observed.angle_sum   = out_chan.angle_sum;
            observed.speed_low   = out_chan.speed_low;
            observed.speed_high  = out_chan.speed_high;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result: %p", observed);
                end
            end
            else
            begin
                wanted = pending_reports.pop_front();
                results_checked++;
                if (observed.matched !== wanted.matched || observed.slot !== wanted.slot
                    || observed.first_frame !== wanted.first_frame
                    || observed.angle_sum !== wanted.angle_sum
                    || observed.speed_low !== wanted.speed_low
                    || observed.speed_high !== wanted.speed_high)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display({"result %0d: expected m=%0b slot=%0d first=%0b",
                                  " sum=%0d min=%0d max=%0d"},
                                 results_checked, wanted.matched, wanted.slot,
                                 wanted.first_frame, wanted.angle_sum, wanted.speed_low,
                                 wanted.speed_high);
                        $display({"result %0d: actual   m=%0b slot=%0d first=%0b",
                                  " sum=%0d min=%0d max=%0d"},
                                 results_checked, observed.matched, observed.slot,
                                 observed.first_frame, observed.angle_sum, observed.speed_low,
                                 observed.speed_high);
                    end
                end
            end
        end
        out_chan.ready <= ($urandom_range(99) >= receiver_idle);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        in_chan.valid       = 1'b0;
        in_chan.frame_id    = '0;
        in_chan.rotor_angle = '0;
        in_chan.speed_rpm   = '0;
        out_chan.ready      = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        rst_n               = 1'b0;
        frames_sent         = 0;
        results_checked     = 0;
        reg_writes          = 0;
        mismatches          = 0;
        cycles              = 0;
        sender_idle         = 31;
        receiver_idle       = 48;
        reset_tracker_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_map();
        test_wrapped_delta();
        test_out_of_range_ids();
        test_duplicate_ids();
        test_random_tracking(31, 48);
        test_random_tracking(48, 31);
        test_random_tracking(0, 0);
        drain_results();

        $display("summary: %0d frames sent, %0d results checked, %0d register writes",
                 frames_sent, results_checked, reg_writes);
        $display("summary: slot maps incl. duplicates and out-of-range ids, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
